// ===== sv/pmw_pkg.sv =====
package pmw_pkg;

    typedef logic signed [23:0] coord_t;
    typedef logic signed [19:0] offs_t;
    typedef logic [18:0] dist_t;

    typedef struct packed {
        coord_t p1x;
        coord_t p1y;
        coord_t p2x;
        coord_t p2y;
        coord_t p3x;
        coord_t p3y;
    } points_t;

    typedef struct packed {
        points_t pts;
        dist_t span;
        logic signed [24:0] d1x;
        logic signed [24:0] d1y;
        logic signed [24:0] d2x;
        logic signed [24:0] d2y;
    } leg_side_t;

    typedef struct packed {
        points_t pts;
        dist_t span;
        logic [3:0] neg;
        logic [1:0] zero;
    } norm_side_t;

    typedef struct packed {
        points_t pts;
        dist_t span;
        logic signed [18:0] sx;
        logic signed [18:0] sy;
        offs_t o1x;
        offs_t o1y;
        offs_t o2x;
        offs_t o2y;
    } bis_side_t;

    typedef struct packed {
        points_t pts;
        offs_t o1x;
        offs_t o1y;
        offs_t o2x;
        offs_t o2y;
        logic negx;
        logic negy;
        logic zero;
    } join_side_t;

    typedef struct packed {
        points_t pts;
        offs_t o1x;
        offs_t o1y;
        offs_t o2x;
        offs_t o2y;
        coord_t jx;
        coord_t jy;
    } corner_t;

    localparam logic [1:0] CFG_PATH_WIDTH = 2'd0;
    localparam logic [1:0] CFG_WALL_THICKNESS = 2'd1;

    localparam logic [1:0] WALL_LEFT_ONE = 2'd0;
    localparam logic [1:0] WALL_LEFT_TWO = 2'd1;
    localparam logic [1:0] WALL_RIGHT_ONE = 2'd2;
    localparam logic [1:0] WALL_RIGHT_TWO = 2'd3;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [16:0] TENTH_Q16 = 17'd6554;

    function automatic logic signed [31:0] rnd16(input logic signed [47:0] v);
        logic [47:0] m;
        logic [47:0] q;
        m = v[47] ? 48'(-v) : 48'(v);
        q = (m + 48'd32768) >> 16;
        return v[47] ? -$signed(q[31:0]) : $signed(q[31:0]);
    endfunction

    function automatic logic signed [17:0] unit_comp(input logic [16:0] q, input logic neg,
                                                     input logic zero);
        logic [16:0] mag;
        mag = (q > ONE_Q16) ? ONE_Q16 : q;
        if (zero)
        begin
            return '0;
        end
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic coord_t sat26(input logic signed [25:0] v);
        if (v > 26'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        if (v < -26'sd8388608)
        begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

endpackage

// ===== sv/polyline_miter_wall_offsets.sv =====
// Miter-joined wall offsets for a two-segment polyline.
// An item (start, corner and finish points, signed Q15.8) is transferred at
// a rising edge where start is high and busy is low. Each item yields four
// wall segments on the result ports, one per cycle on consecutive cycles,
// each marked by result_valid for exactly one cycle, in wall_index order;
// final_wall marks the fourth.
// The pipeline is two 32-step and 25-step square root units and two 17-step
// and 23-step dividers, one radix-2 step per stage, plus registered multiply
// stages. A new item may be taken while earlier ones are still in flight,
// but after each transfer busy stays high until a gap counter runs down,
// which keeps the four walls of one item clear of those of the next.
// The receiver cannot stall; results come out on their fixed schedule.
// Configuration writes (cfg_index 0 path width, 1 wall thickness) are always
// ready and take effect for items accepted afterwards; other indexes are
// ignored. Reset clears the pipeline and sets path width 16, wall thickness 4.
module polyline_miter_wall_offsets (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  pmw_pkg::coord_t start_x,
    input  pmw_pkg::coord_t start_y,
    input  pmw_pkg::coord_t corner_x,
    input  pmw_pkg::coord_t corner_y,
    input  pmw_pkg::coord_t finish_x,
    input  pmw_pkg::coord_t finish_y,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [9:0]      cfg_data,
    output logic            result_valid,
    output logic [1:0]      wall_index,
    output pmw_pkg::coord_t edge_ax,
    output pmw_pkg::coord_t edge_ay,
    output pmw_pkg::coord_t edge_bx,
    output pmw_pkg::coord_t edge_by,
    output logic            final_wall
);

    logic [9:0] pw_reg;
    logic [9:0] wt_reg;
    logic [1:0] gap_reg;
    logic       accept;

    assign accept    = start && !busy;
    assign busy      = (gap_reg != 2'd0);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg <= 10'd16;
            wt_reg <= 10'd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pmw_pkg::CFG_PATH_WIDTH:     pw_reg <= cfg_data;
                pmw_pkg::CFG_WALL_THICKNESS: wt_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= '0;
        end
        else if (accept)
        begin
            gap_reg <= 2'd3;
        end
        else if (gap_reg != 2'd0)
        begin
            gap_reg <= gap_reg - 2'd1;
        end
    end

    // Front stages: capture, leg deltas, squared lengths.
    logic s0_vld_reg, s1_vld_reg, s2_vld_reg;
    pmw_pkg::points_t s0_pts_reg, s1_pts_reg;
    pmw_pkg::dist_t   s0_dist_reg, s1_dist_reg;
    logic signed [24:0] s1_d1x_reg, s1_d1y_reg, s1_d2x_reg, s1_d2y_reg;
    pmw_pkg::leg_side_t s2_side_reg;
    logic [49:0] s2_l2a_reg, s2_l2b_reg;
    logic signed [49:0] sq_a1, sq_a2, sq_b1, sq_b2;

    assign sq_a1 = s1_d1x_reg * s1_d1x_reg;
    assign sq_a2 = s1_d1y_reg * s1_d1y_reg;
    assign sq_b1 = s1_d2x_reg * s1_d2x_reg;
    assign sq_b2 = s1_d2y_reg * s1_d2y_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_pts_reg  <= '{start_x, start_y, corner_x, corner_y, finish_x, finish_y};
            s0_dist_reg <= 19'({pw_reg, 7'b0}) + 19'({wt_reg, 8'b0});
        end
        s1_pts_reg  <= s0_pts_reg;
        s1_dist_reg <= s0_dist_reg;
        s1_d1x_reg  <= 25'(s0_pts_reg.p2x) - 25'(s0_pts_reg.p1x);
        s1_d1y_reg  <= 25'(s0_pts_reg.p2y) - 25'(s0_pts_reg.p1y);
        s1_d2x_reg  <= 25'(s0_pts_reg.p3x) - 25'(s0_pts_reg.p2x);
        s1_d2y_reg  <= 25'(s0_pts_reg.p3y) - 25'(s0_pts_reg.p2y);
        s2_side_reg <= '{s1_pts_reg, s1_dist_reg, s1_d1x_reg, s1_d1y_reg,
                         s1_d2x_reg, s1_d2y_reg};
        s2_l2a_reg  <= $unsigned(sq_a1) + $unsigned(sq_a2);
        s2_l2b_reg  <= $unsigned(sq_b1) + $unsigned(sq_b2);
    end

    // Leg lengths.
    logic                 sa_vld;
    logic [1:0][31:0]     sa_root;
    pmw_pkg::leg_side_t   sa_side;

    pmw_sqrt #(
        .W(64),
        .LANES(2),
        .SW($bits(pmw_pkg::leg_side_t))
    ) u_sqrt_leg (
        .clk(clk),
        .rst_n(rst_n),
        .in_vld(s2_vld_reg),
        .in_rad({{s2_l2b_reg, 14'b0}, {s2_l2a_reg, 14'b0}}),
        .in_side(s2_side_reg),
        .out_vld(sa_vld),
        .out_root(sa_root),
        .out_side(sa_side)
    );

    // Division setup for the four unit components.
    logic                 s3_vld_reg;
    logic [3:0][47:0]     s3_num_reg;
    logic [3:0][31:0]     s3_den_reg;
    pmw_pkg::norm_side_t  s3_side_reg;
    logic [3:0][24:0]     comp_mag;
    logic [3:0]           comp_neg;
    logic signed [24:0]   comp_val [4];

    assign comp_val[0] = sa_side.d1x;
    assign comp_val[1] = sa_side.d1y;
    assign comp_val[2] = sa_side.d2x;
    assign comp_val[3] = sa_side.d2y;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            comp_neg[i] = comp_val[i][24];
            comp_mag[i] = comp_val[i][24] ? 25'(-comp_val[i]) : 25'(comp_val[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            s3_num_reg[i] <= {comp_mag[i], 23'b0} + 48'(sa_root[i/2] >> 1);
            s3_den_reg[i] <= sa_root[i/2];
        end
        s3_side_reg <= '{sa_side.pts, sa_side.span, comp_neg,
                         {sa_root[1] == 32'd0, sa_root[0] == 32'd0}};
    end

    logic                 da_vld;
    logic [3:0][16:0]     da_quo;
    pmw_pkg::norm_side_t  da_side;

    pmw_div #(
        .NW(48),
        .DW(32),
        .QB(17),
        .LANES(4),
        .SW($bits(pmw_pkg::norm_side_t))
    ) u_div_unit (
        .clk(clk),
        .rst_n(rst_n),
        .in_vld(s3_vld_reg),
        .in_num(s3_num_reg),
        .in_den(s3_den_reg),
        .in_side(s3_side_reg),
        .out_vld(da_vld),
        .out_quo(da_quo),
        .out_side(da_side)
    );

    // Normals, their products, squared bisector length and corner dot product.
    logic s4_vld_reg, s5_vld_reg, s6_vld_reg, s7_vld_reg, s8_vld_reg;
    logic signed [17:0] s4_n1x_reg, s4_n1y_reg, s4_n2x_reg, s4_n2y_reg;
    pmw_pkg::points_t s4_pts_reg, s5_pts_reg, s6_pts_reg, s7_pts_reg;
    pmw_pkg::dist_t   s4_dist_reg, s5_dist_reg, s6_dist_reg, s7_dist_reg;
    logic signed [18:0] s5_sx_reg, s5_sy_reg, s6_sx_reg, s6_sy_reg, s7_sx_reg, s7_sy_reg;
    logic signed [35:0] s5_pnx_reg, s5_pny_reg;
    logic signed [37:0] s5_ond_reg [4];
    logic signed [37:0] sqx, sqy;
    logic [35:0]        s6_l2_reg, s7_l2_reg;
    logic signed [36:0] s6_dot_reg;
    pmw_pkg::offs_t     s6_o_reg [4];
    pmw_pkg::offs_t     s7_o_reg [4];
    logic signed [18:0] s7_dot_reg;
    logic [1:0][49:0]   s8_rad_reg;
    pmw_pkg::bis_side_t s8_side_reg;
    logic signed [19:0] cv;
    logic [19:0]        cv_mag;
    logic [19:0]        cv_half;
    logic [16:0]        c_val;
    logic signed [19:0] dist_s;

    assign dist_s = $signed({1'b0, s4_dist_reg});
    assign sqx = s5_sx_reg * s5_sx_reg;
    assign sqy = s5_sy_reg * s5_sy_reg;

    always_comb
    begin
        cv      = 20'sd65536 + 20'(s7_dot_reg);
        cv_mag  = cv[19] ? 20'(-cv) : 20'(cv);
        cv_half = (cv_mag + 20'd1) >> 1;
        if (cv[19])
        begin
            c_val = '0;
        end
        else if (cv_half > 20'(pmw_pkg::ONE_Q16))
        begin
            c_val = pmw_pkg::ONE_Q16;
        end
        else
        begin
            c_val = cv_half[16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s4_n1x_reg  <= -pmw_pkg::unit_comp(da_quo[1], da_side.neg[1], da_side.zero[0]);
        s4_n1y_reg  <= pmw_pkg::unit_comp(da_quo[0], da_side.neg[0], da_side.zero[0]);
        s4_n2x_reg  <= -pmw_pkg::unit_comp(da_quo[3], da_side.neg[3], da_side.zero[1]);
        s4_n2y_reg  <= pmw_pkg::unit_comp(da_quo[2], da_side.neg[2], da_side.zero[1]);
        s4_pts_reg  <= da_side.pts;
        s4_dist_reg <= da_side.span;

        s5_sx_reg     <= 19'(s4_n1x_reg) + 19'(s4_n2x_reg);
        s5_sy_reg     <= 19'(s4_n1y_reg) + 19'(s4_n2y_reg);
        s5_pnx_reg    <= s4_n1x_reg * s4_n2x_reg;
        s5_pny_reg    <= s4_n1y_reg * s4_n2y_reg;
        s5_ond_reg[0] <= s4_n1x_reg * dist_s;
        s5_ond_reg[1] <= s4_n1y_reg * dist_s;
        s5_ond_reg[2] <= s4_n2x_reg * dist_s;
        s5_ond_reg[3] <= s4_n2y_reg * dist_s;
        s5_pts_reg    <= s4_pts_reg;
        s5_dist_reg   <= s4_dist_reg;

        s6_l2_reg   <= 36'($unsigned(sqx)) + 36'($unsigned(sqy));
        s6_dot_reg  <= 37'(s5_pnx_reg) + 37'(s5_pny_reg);
        for (int i = 0; i < 4; i++)
        begin
            s6_o_reg[i] <= 20'(pmw_pkg::rnd16(48'(s5_ond_reg[i])));
        end
        s6_sx_reg   <= s5_sx_reg;
        s6_sy_reg   <= s5_sy_reg;
        s6_pts_reg  <= s5_pts_reg;
        s6_dist_reg <= s5_dist_reg;

        s7_dot_reg  <= 19'(pmw_pkg::rnd16(48'(s6_dot_reg)));
        s7_l2_reg   <= s6_l2_reg;
        s7_o_reg    <= s6_o_reg;
        s7_sx_reg   <= s6_sx_reg;
        s7_sy_reg   <= s6_sy_reg;
        s7_pts_reg  <= s6_pts_reg;
        s7_dist_reg <= s6_dist_reg;

        s8_rad_reg[0] <= {s7_l2_reg, 14'b0};
        s8_rad_reg[1] <= 50'({c_val, 16'b0});
        s8_side_reg   <= '{s7_pts_reg, s7_dist_reg, s7_sx_reg, s7_sy_reg,
                           s7_o_reg[0], s7_o_reg[1], s7_o_reg[2], s7_o_reg[3]};
    end

    // Bisector length and miter root.
    logic                 sb_vld;
    logic [1:0][24:0]     sb_root;
    pmw_pkg::bis_side_t   sb_side;

    pmw_sqrt #(
        .W(50),
        .LANES(2),
        .SW($bits(pmw_pkg::bis_side_t))
    ) u_sqrt_join (
        .clk(clk),
        .rst_n(rst_n),
        .in_vld(s8_vld_reg),
        .in_rad(s8_rad_reg),
        .in_side(s8_side_reg),
        .out_vld(sb_vld),
        .out_root(sb_root),
        .out_side(sb_side)
    );

    logic                 s9_vld_reg;
    logic [2:0][40:0]     s9_num_reg;
    logic [2:0][24:0]     s9_den_reg;
    pmw_pkg::join_side_t  s9_side_reg;
    logic [16:0]          miter_den;
    logic [17:0]          sx_mag, sy_mag;

    assign miter_den = (sb_root[1][16:0] > pmw_pkg::TENTH_Q16) ? sb_root[1][16:0]
                                                                 : pmw_pkg::TENTH_Q16;
    assign sx_mag = sb_side.sx[18] ? 18'(-sb_side.sx) : 18'(sb_side.sx);
    assign sy_mag = sb_side.sy[18] ? 18'(-sb_side.sy) : 18'(sb_side.sy);

    always_ff @(posedge clk)
    begin
        s9_num_reg[0] <= {sx_mag, 23'b0} + 41'(sb_root[0] >> 1);
        s9_num_reg[1] <= {sy_mag, 23'b0} + 41'(sb_root[0] >> 1);
        s9_num_reg[2] <= 41'({sb_side.span, 16'b0}) + 41'(miter_den >> 1);
        s9_den_reg[0] <= sb_root[0];
        s9_den_reg[1] <= sb_root[0];
        s9_den_reg[2] <= 25'(miter_den);
        s9_side_reg   <= '{sb_side.pts, sb_side.o1x, sb_side.o1y, sb_side.o2x,
                           sb_side.o2y, sb_side.sx[18], sb_side.sy[18],
                           sb_root[0] == 25'd0};
    end

    logic                 db_vld;
    logic [2:0][22:0]     db_quo;
    pmw_pkg::join_side_t  db_side;

    pmw_div #(
        .NW(41),
        .DW(25),
        .QB(23),
        .LANES(3),
        .SW($bits(pmw_pkg::join_side_t))
    ) u_div_join (
        .clk(clk),
        .rst_n(rst_n),
        .in_vld(s9_vld_reg),
        .in_num(s9_num_reg),
        .in_den(s9_den_reg),
        .in_side(s9_side_reg),
        .out_vld(db_vld),
        .out_quo(db_quo),
        .out_side(db_side)
    );

    // Miter offset at the corner.
    logic s10_vld_reg, s11_vld_reg, s12_vld_reg;
    logic signed [17:0] s10_bx_reg, s10_by_reg;
    logic [22:0]        s10_scale_reg;
    pmw_pkg::join_side_t s10_side_reg, s11_side_reg, s12_side_reg;
    logic signed [41:0] s11_jx_reg, s11_jy_reg;
    pmw_pkg::coord_t    s12_jx_reg, s12_jy_reg;
    pmw_pkg::corner_t   corner;

    always_ff @(posedge clk)
    begin
        s10_bx_reg    <= pmw_pkg::unit_comp(db_quo[0][16:0], db_side.negx, db_side.zero);
        s10_by_reg    <= pmw_pkg::unit_comp(db_quo[1][16:0], db_side.negy, db_side.zero);
        s10_scale_reg <= db_quo[2];
        s10_side_reg  <= db_side;

        s11_jx_reg   <= s10_bx_reg * $signed({1'b0, s10_scale_reg});
        s11_jy_reg   <= s10_by_reg * $signed({1'b0, s10_scale_reg});
        s11_side_reg <= s10_side_reg;

        s12_jx_reg   <= 24'(pmw_pkg::rnd16(48'(s11_jx_reg)));
        s12_jy_reg   <= 24'(pmw_pkg::rnd16(48'(s11_jy_reg)));
        s12_side_reg <= s11_side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg  <= accept;
            s1_vld_reg  <= s0_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= sa_vld;
            s4_vld_reg  <= da_vld;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= sb_vld;
            s10_vld_reg <= db_vld;
            s11_vld_reg <= s10_vld_reg;
            s12_vld_reg <= s11_vld_reg;
        end
    end

    assign corner = '{s12_side_reg.pts, s12_side_reg.o1x, s12_side_reg.o1y,
                      s12_side_reg.o2x, s12_side_reg.o2y, s12_jx_reg, s12_jy_reg};

    pmw_wall_out u_wall_out (
        .clk(clk),
        .rst_n(rst_n),
        .in_vld(s12_vld_reg),
        .in_corner(corner),
        .result_valid(result_valid),
        .wall_index(wall_index),
        .edge_ax(edge_ax),
        .edge_ay(edge_ay),
        .edge_bx(edge_bx),
        .edge_by(edge_by),
        .final_wall(final_wall)
    );

endmodule

// ===== sv/pmw_sqrt.sv =====
module pmw_sqrt #(
    parameter int W = 64,
    parameter int LANES = 2,
    parameter int SW = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    input  logic [LANES-1:0][W-1:0]       in_rad,
    input  logic [SW-1:0]                 in_side,
    output logic                          out_vld,
    output logic [LANES-1:0][W/2-1:0]     out_root,
    output logic [SW-1:0]                 out_side
);

    localparam int RW = W / 2;

    logic                          vld_st  [RW+1];
    logic [LANES-1:0][W-1:0]       rad_st  [RW+1];
    logic [LANES-1:0][RW+1:0]      rem_st  [RW+1];
    logic [LANES-1:0][RW-1:0]      root_st [RW+1];
    logic [SW-1:0]                 side_st [RW+1];

    assign vld_st[0]  = in_vld;
    assign rad_st[0]  = in_rad;
    assign rem_st[0]  = '0;
    assign root_st[0] = '0;
    assign side_st[0] = in_side;

    genvar k;
    generate
        for (k = 0; k < RW; k++)
        begin : g_stage
            localparam int I = RW - 1 - k;
            logic                     vld_reg;
            logic [LANES-1:0][W-1:0]  rad_reg;
            logic [LANES-1:0][RW+1:0] rem_reg;
            logic [LANES-1:0][RW-1:0] root_reg;
            logic [SW-1:0]            side_reg;
            logic [LANES-1:0][RW+1:0] rem_next;
            logic [LANES-1:0][RW-1:0] root_next;

            always_comb
            begin
                logic [RW+1:0] trial;
                logic [RW+1:0] test;
                for (int l = 0; l < LANES; l++)
                begin
                    trial = {rem_st[k][l][RW-1:0], rad_st[k][l][2*I+1 -: 2]};
                    test  = {root_st[k][l], 2'b01};
                    if (trial >= test)
                    begin
                        rem_next[l]  = trial - test;
                        root_next[l] = {root_st[k][l][RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l]  = trial;
                        root_next[l] = {root_st[k][l][RW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg <= 1'b0;
                end
                else
                begin
                    vld_reg <= vld_st[k];
                end
            end

            always_ff @(posedge clk)
            begin
                rad_reg  <= rad_st[k];
                rem_reg  <= rem_next;
                root_reg <= root_next;
                side_reg <= side_st[k];
            end

            assign vld_st[k+1]  = vld_reg;
            assign rad_st[k+1]  = rad_reg;
            assign rem_st[k+1]  = rem_reg;
            assign root_st[k+1] = root_reg;
            assign side_st[k+1] = side_reg;
        end
    endgenerate

    assign out_vld  = vld_st[RW];
    assign out_root = root_st[RW];
    assign out_side = side_st[RW];

endmodule

// ===== sv/pmw_div.sv =====
module pmw_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QB = 17,
    parameter int LANES = 4,
    parameter int SW = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_vld,
    input  logic [LANES-1:0][NW-1:0]  in_num,
    input  logic [LANES-1:0][DW-1:0]  in_den,
    input  logic [SW-1:0]             in_side,
    output logic                      out_vld,
    output logic [LANES-1:0][QB-1:0]  out_quo,
    output logic [SW-1:0]             out_side
);

    localparam int CW = (NW > DW + QB) ? NW : DW + QB;

    logic                      vld_st  [QB+1];
    logic [LANES-1:0][NW-1:0]  rem_st  [QB+1];
    logic [LANES-1:0][DW-1:0]  den_st  [QB+1];
    logic [LANES-1:0][QB-1:0]  quo_st  [QB+1];
    logic [SW-1:0]             side_st [QB+1];

    assign vld_st[0]  = in_vld;
    assign rem_st[0]  = in_num;
    assign den_st[0]  = in_den;
    assign quo_st[0]  = '0;
    assign side_st[0] = in_side;

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_stage
            localparam int I = QB - 1 - k;
            logic                     vld_reg;
            logic [LANES-1:0][NW-1:0] rem_reg;
            logic [LANES-1:0][DW-1:0] den_reg;
            logic [LANES-1:0][QB-1:0] quo_reg;
            logic [SW-1:0]            side_reg;
            logic [LANES-1:0][NW-1:0] rem_next;
            logic [LANES-1:0][QB-1:0] quo_next;

            always_comb
            begin
                logic [CW-1:0] wide_rem;
                logic [CW-1:0] wide_den;
                for (int l = 0; l < LANES; l++)
                begin
                    wide_rem = CW'(rem_st[k][l]);
                    wide_den = CW'(den_st[k][l]) << I;
                    if (wide_rem >= wide_den)
                    begin
                        rem_next[l] = NW'(wide_rem - wide_den);
                        quo_next[l] = {quo_st[k][l][QB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = rem_st[k][l];
                        quo_next[l] = {quo_st[k][l][QB-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg <= 1'b0;
                end
                else
                begin
                    vld_reg <= vld_st[k];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg  <= rem_next;
                den_reg  <= den_st[k];
                quo_reg  <= quo_next;
                side_reg <= side_st[k];
            end

            assign vld_st[k+1]  = vld_reg;
            assign rem_st[k+1]  = rem_reg;
            assign den_st[k+1]  = den_reg;
            assign quo_st[k+1]  = quo_reg;
            assign side_st[k+1] = side_reg;
        end
    endgenerate

    assign out_vld  = vld_st[QB];
    assign out_quo  = quo_st[QB];
    assign out_side = side_st[QB];

endmodule

// ===== sv/pmw_wall_out.sv =====
module pmw_wall_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  pmw_pkg::corner_t  in_corner,
    output logic              result_valid,
    output logic [1:0]        wall_index,
    output pmw_pkg::coord_t   edge_ax,
    output pmw_pkg::coord_t   edge_ay,
    output pmw_pkg::coord_t   edge_bx,
    output pmw_pkg::coord_t   edge_by,
    output logic              final_wall
);

    pmw_pkg::coord_t la_x_reg, la_y_reg, lj_x_reg, lj_y_reg, lb_x_reg, lb_y_reg;
    pmw_pkg::coord_t ra_x_reg, ra_y_reg, rj_x_reg, rj_y_reg, rb_x_reg, rb_y_reg;
    logic [1:0] cnt_reg;
    logic       act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            act_reg <= 1'b0;
        end
        else if (in_vld)
        begin
            cnt_reg <= pmw_pkg::WALL_LEFT_ONE;
            act_reg <= 1'b1;
        end
        else if (act_reg)
        begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg == pmw_pkg::WALL_RIGHT_TWO)
            begin
                act_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            la_x_reg <= pmw_pkg::sat26(26'(in_corner.pts.p1x) + 26'(in_corner.o1x));
            la_y_reg <= pmw_pkg::sat26(26'(in_corner.pts.p1y) + 26'(in_corner.o1y));
            lj_x_reg <= pmw_pkg::sat26(26'(in_corner.pts.p2x) + 26'(in_corner.jx));
            lj_y_reg <= pmw_pkg::sat26(26'(in_corner.pts.p2y) + 26'(in_corner.jy));
            lb_x_reg <= pmw_pkg::sat26(26'(in_corner.pts.p3x) + 26'(in_corner.o2x));
            lb_y_reg <= pmw_pkg::sat26(26'(in_corner.pts.p3y) + 26'(in_corner.o2y));
            ra_x_reg <= pmw_pkg::sat26(26'(in_corner.pts.p1x) - 26'(in_corner.o1x));
            ra_y_reg <= pmw_pkg::sat26(26'(in_corner.pts.p1y) - 26'(in_corner.o1y));
            rj_x_reg <= pmw_pkg::sat26(26'(in_corner.pts.p2x) - 26'(in_corner.jx));
            rj_y_reg <= pmw_pkg::sat26(26'(in_corner.pts.p2y) - 26'(in_corner.jy));
            rb_x_reg <= pmw_pkg::sat26(26'(in_corner.pts.p3x) - 26'(in_corner.o2x));
            rb_y_reg <= pmw_pkg::sat26(26'(in_corner.pts.p3y) - 26'(in_corner.o2y));
        end
    end

    always_comb
    begin
        unique case (cnt_reg)
            pmw_pkg::WALL_LEFT_ONE:
            begin
                edge_ax = la_x_reg;
                edge_ay = la_y_reg;
                edge_bx = lj_x_reg;
                edge_by = lj_y_reg;
            end
            pmw_pkg::WALL_LEFT_TWO:
            begin
                edge_ax = lj_x_reg;
                edge_ay = lj_y_reg;
                edge_bx = lb_x_reg;
                edge_by = lb_y_reg;
            end
            pmw_pkg::WALL_RIGHT_ONE:
            begin
                edge_ax = ra_x_reg;
                edge_ay = ra_y_reg;
                edge_bx = rj_x_reg;
                edge_by = rj_y_reg;
            end
            default:
            begin
                edge_ax = rj_x_reg;
                edge_ay = rj_y_reg;
                edge_bx = rb_x_reg;
                edge_by = rb_y_reg;
            end
        endcase
    end

    assign result_valid = act_reg;
    assign wall_index   = cnt_reg;
    assign final_wall   = (cnt_reg == pmw_pkg::WALL_RIGHT_TWO);

endmodule

// ===== dv/polyline_miter_wall_offsets_tb.sv =====
`timescale 1ns / 100ps

module polyline_miter_wall_offsets_tb;

    typedef struct {
        logic signed [23:0] p [6];
    } polyline_t;

    typedef struct {
        logic [1:0] idx;
        logic [23:0] ax;
        logic [23:0] ay;
        logic [23:0] bx;
        logic [23:0] by;
        logic fin;
    } wall_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    pmw_pkg::coord_t start_x = '0, start_y = '0, corner_x = '0, corner_y = '0;
    pmw_pkg::coord_t finish_x = '0, finish_y = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;
    logic result_valid;
    logic [1:0] wall_index;
    pmw_pkg::coord_t edge_ax, edge_ay, edge_bx, edge_by;
    logic final_wall;
    logic busy_was = 1'b1;

    polyline_miter_wall_offsets uut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    polyline_t pending_lines [$];
    wall_t expected_walls [$];
    longint width_q8_path = 16;
    longint width_thick = 4;
    int errors = 0;
    int idle_left = 0;
    bit quiet = 0;
    int walls_seen = 0;
    int lines_sent = 0;
    int stall_cycles = 0;

    function automatic longint isqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
            begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint rdiv(longint num, longint den);
        longint m = num < 0 ? -num : num;
        longint q = (m + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic normalize(input longint x, input longint y, output longint ux,
                             output longint uy);
        longint r;
        if (x * x + y * y == 0)
        begin
            ux = 0;
            uy = 0;
        end
        else
        begin
            r = isqrt((x * x + y * y) << 14);
            ux = clampl(rdiv(x * 8388608, r), -65536, 65536);
            uy = clampl(rdiv(y * 8388608, r), -65536, 65536);
        end
    endtask

    function automatic logic [23:0] sat24(longint v);
        return 24'(clampl(v, -8388608, 8388607));
    endfunction

    task automatic push_wall(input logic [1:0] i, input longint ax, input longint ay,
                             input longint bx, input longint by);
        wall_t w;
        w.idx = i;
        w.ax = sat24(ax);
        w.ay = sat24(ay);
        w.bx = sat24(bx);
        w.by = sat24(by);
        w.fin = (i == pmw_pkg::WALL_RIGHT_TWO);
        expected_walls.push_back(w);
    endtask

    task automatic predict_walls(input polyline_t pl);
        longint x1, y1, x2, y2, x3, y3, d, ux, uy, n1x, n1y, n2x, n2y, bx, by;
        longint dt, c, root, den, scale, jx, jy, o1x, o1y, o2x, o2y;
        x1 = pl.p[0]; y1 = pl.p[1]; x2 = pl.p[2];
        y2 = pl.p[3]; x3 = pl.p[4]; y3 = pl.p[5];
        d = width_q8_path * 128 + width_thick * 256;
        normalize(x2 - x1, y2 - y1, ux, uy);
        n1x = -uy;
        n1y = ux;
        normalize(x3 - x2, y3 - y2, ux, uy);
        n2x = -uy;
        n2y = ux;
        normalize(n1x + n2x, n1y + n2y, bx, by);
        dt = rdiv(n1x * n2x + n1y * n2y, 65536);
        c = clampl(rdiv(65536 + dt, 2), 0, 65536);
        root = isqrt(c << 16);
        den = root > 6554 ? root : 6554;
        scale = rdiv(d * 65536, den);
        jx = rdiv(bx * scale, 65536);
        jy = rdiv(by * scale, 65536);
        o1x = rdiv(n1x * d, 65536);
        o1y = rdiv(n1y * d, 65536);
        o2x = rdiv(n2x * d, 65536);
        o2y = rdiv(n2y * d, 65536);
        push_wall(pmw_pkg::WALL_LEFT_ONE, x1 + o1x, y1 + o1y, x2 + jx, y2 + jy);
        push_wall(pmw_pkg::WALL_LEFT_TWO, x2 + jx, y2 + jy, x3 + o2x, y3 + o2y);
        push_wall(pmw_pkg::WALL_RIGHT_ONE, x1 - o1x, y1 - o1y, x2 - jx, y2 - jy);
        push_wall(pmw_pkg::WALL_RIGHT_TWO, x2 - jx, y2 - jy, x3 - o2x, y3 - o2y);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && !cfg_valid)
        begin
            if (start && !busy_was)
            begin
                start <= 1'b0;
            end
            else if (!start)
            begin
                if (idle_left > 0)
                begin
                    idle_left <= idle_left - 1;
                end
                else if (pending_lines.size() > 0)
                begin
                    start_x <= pending_lines[0].p[0];
                    start_y <= pending_lines[0].p[1];
                    corner_x <= pending_lines[0].p[2];
                    corner_y <= pending_lines[0].p[3];
                    finish_x <= pending_lines[0].p[4];
                    finish_y <= pending_lines[0].p[5];
                    start <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                    begin
                        idle_left <= $urandom_range(1, 16);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        bit took;
        took = 1'b0;
        if (rst_n && start && !busy)
        begin
            predict_walls(pending_lines.pop_front());
            lines_sent <= lines_sent + 1;
            took = 1'b1;
        end
        busy_was <= !(rst_n && start && !busy);
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == pmw_pkg::CFG_PATH_WIDTH)
            begin
                width_q8_path = cfg_data;
            end
            else if (cfg_index == pmw_pkg::CFG_WALL_THICKNESS)
            begin
                width_thick = cfg_data;
            end
        end
        if (rst_n && result_valid)
        begin
            took = 1'b1;
            walls_seen <= walls_seen + 1;
            if (expected_walls.size() == 0)
            begin
                $error("unexpected wall result, wall_index %0d", wall_index);
                errors++;
            end
            else
            begin
                wall_t w;
                w = expected_walls.pop_front();
                if (wall_index !== w.idx)
                begin
                    $error("wall_index expected %0d actual %0d", w.idx, wall_index);
                    errors++;
                end
                if (edge_ax !== w.ax)
                begin
                    $error("edge_ax expected %h actual %h", w.ax, edge_ax);
                    errors++;
                end
                if (edge_ay !== w.ay)
                begin
                    $error("edge_ay expected %h actual %h", w.ay, edge_ay);
                    errors++;
                end
                if (edge_bx !== w.bx)
                begin
                    $error("edge_bx expected %h actual %h", w.bx, edge_bx);
                    errors++;
                end
                if (edge_by !== w.by)
                begin
                    $error("edge_by expected %h actual %h", w.by, edge_by);
                    errors++;
                end
                if (final_wall !== w.fin)
                begin
                    $error("final_wall expected %0d actual %0d", w.fin, final_wall);
                    errors++;
                end
            end
        end
        stall_cycles <= took ? 0 : stall_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (stall_cycles > 2000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF - 24'($urandom_range(0, 3));
            1: return 24'sh800000 + 24'($urandom_range(0, 3));
            2: return 24'($urandom);
            default: return 24'($signed($urandom_range(0, 16383)) - 8192);
        endcase
    endfunction

    task automatic add_line(input longint a, input longint b, input longint c,
                            input longint e, input longint f, input longint g);
        polyline_t pl;
        pl.p[0] = 24'(a); pl.p[1] = 24'(b); pl.p[2] = 24'(c);
        pl.p[3] = 24'(e); pl.p[4] = 24'(f); pl.p[5] = 24'(g);
        pending_lines.push_back(pl);
    endtask

    task automatic add_random(input int n);
        polyline_t pl;
        for (int i = 0; i < n; i++)
        begin
            for (int k = 0; k < 6; k++)
            begin
                pl.p[k] = rand_coord();
            end
            case ($urandom_range(0, 7))
                0:
                begin
                    pl.p[2] = pl.p[0];
                    pl.p[3] = pl.p[1];
                end
                1:
                begin
                    pl.p[4] = pl.p[0];
                    pl.p[5] = pl.p[1];
                end
                2:
                begin
                    pl.p[4] = pl.p[2];
                    pl.p[5] = pl.p[3];
                end
                default: ;
            endcase
            pending_lines.push_back(pl);
        end
    endtask

    task automatic drain();
        while (pending_lines.size() > 0 || expected_walls.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (130) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] i, input logic [9:0] v);
        @(negedge clk);
        cfg_index <= i;
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        add_line(0, 0, 2560, 0, 2560, 2560);
        add_line(0, 0, 0, 0, 0, 0);
        add_line(0, 0, 2560, 0, 0, 0);
        add_line(0, 0, 2560, 0, 5120, 0);
        add_line(8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
        add_line(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608);
        add_line(-8388608, -8388608, 8388607, 8388607, -8388608, 8388607);
        add_line(8388600, 0, 8388607, 0, 8388607, 100);
        add_line(0, 0, 256, 1, 0, 2);
        add_line(-8388608, 8388607, 8388607, -8388608, 0, 0);
        drain();
        write_reg(pmw_pkg::CFG_PATH_WIDTH, 10'd1023);
        write_reg(pmw_pkg::CFG_WALL_THICKNESS, 10'd1023);
        write_reg(2'd2, 10'd55);
        write_reg(2'd3, 10'd1);
        add_line(8388000, 8388000, 8388300, 8388000, 8388300, 8388300);
        add_line(0, 0, 2560, 0, 0, 1);
        add_random(100);
        drain();
        write_reg(pmw_pkg::CFG_PATH_WIDTH, 10'd0);
        write_reg(pmw_pkg::CFG_WALL_THICKNESS, 10'd0);
        add_random(60);
        drain();
        write_reg(pmw_pkg::CFG_PATH_WIDTH, 10'($urandom));
        write_reg(pmw_pkg::CFG_WALL_THICKNESS, 10'($urandom));
        add_random(100);
        drain();
        quiet = 1;
        write_reg(pmw_pkg::CFG_PATH_WIDTH, 10'd16);
        write_reg(pmw_pkg::CFG_WALL_THICKNESS, 10'd4);
        add_random(60);
        drain();
        $display("Sent %0d polylines and checked %0d walls over five register settings.",
                 lines_sent, walls_seen);
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
